FILE: design/des_block_cipher_modes_macros.svh
// assertion macros used by the des block cipher controller
`ifndef DES_BLOCK_CIPHER_MODES_MACROS_SVH
`define DES_BLOCK_CIPHER_MODES_MACROS_SVH
`ifndef SYNTHESIS
`define DBC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define DBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DBC_ASSERT(label, clk, rst_n, prop)
`define DBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/dbc_pkg.sv
// types, constants and des permutation functions for the des block cipher
`default_nettype none
package dbc_pkg;

  localparam int unsigned NumRounds = 16;
  localparam int unsigned RndW = 4;

  localparam logic [2:0] ModeEcb = 3'd0;
  localparam logic [2:0] ModeCbc = 3'd1;
  localparam logic [2:0] ModeCfb = 3'd2;
  localparam logic [2:0] ModeOfb = 3'd3;
  localparam logic [2:0] ModeCtr = 3'd4;

  localparam logic [1:0] RegKey  = 2'd0;
  localparam logic [1:0] RegIv   = 2'd1;
  localparam logic [1:0] RegMode = 2'd2;
  localparam logic [1:0] RegEnc  = 2'd3;

  // command from controller to datapath
  typedef struct packed {
    logic load;   // capture beat, set up round input
    logic round;  // run one feistel round
    logic finish; // form result and update chain value
  } dbc_cmd_t;

  typedef logic [7:0] tab64_t [64];
  typedef logic [5:0] tab48_t [48];
  typedef logic [5:0] tab56_t [56];
  typedef logic [5:0] tab32_t [32];
  typedef logic [3:0] sbox_t  [8][64];

  localparam tab64_t TabIp = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam tab64_t TabFp = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam tab48_t TabE = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam tab32_t TabP = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam tab56_t TabPc1 = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam tab48_t TabPc2 = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam sbox_t TabS = '{
   '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
     4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
   '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
     0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
   '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
     13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
   '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
     10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
   '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
     4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
   '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
     9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
   '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
     1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
   '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
     7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // des numbering: bit 1 is the msb
  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-TabIp[i]];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-TabFp[i]];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-TabPc1[i]];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-TabPc2[i]];
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-TabE[i]];
    e = e ^ k;
    for (int j = 0; j < 8; j++) begin
      six = e[42-6*j +: 6];
      s[28-4*j +: 4] = TabS[j][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-TabP[i]];
    return p;
  endfunction

  // left rotation of both key halves, per round
  function automatic logic [1:0] rot_amount(input logic [RndW-1:0] rnd);
    logic [1:0] a;
    unique case (rnd)
      4'd0, 4'd1, 4'd8, 4'd15: a = 2'd1;
      default:                 a = 2'd2;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: design/des_block_cipher_modes.sv
// top level: des with ecb, cbc, cfb, ofb and ctr chaining, apb config, stream data
// each input beat passes through load, the feistel rounds and finish to give its result beat
// a new block is taken only once the last one has finished, as set by the single shared feistel round unit
// the result register frees the round unit while a result waits to be taken
// reset: asynchronous active low; key 0 (zero schedule), iv 0, ecb, encrypt, chain 0
`default_nettype none
module des_block_cipher_modes (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // data_block
  input  wire logic        s_axis_tuser,   // restart_chain
  input  wire logic        s_axis_tlast,   // last_block
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // result_block
  output logic             m_axis_tlast    // result_last
);
  logic [63:0] key_q, iv_q;
  logic [2:0]  mode_q;
  logic        enc_q;
  logic        wr;
  logic [1:0]  reg_idx;
  dbc_pkg::dbc_cmd_t        cmd;
  logic [dbc_pkg::RndW-1:0] rnd;
  logic                     out_free;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && (paddr[2:0] == 3'd0);
  assign reg_idx = paddr[4:3];

  always_comb begin
    unique case (reg_idx)
      dbc_pkg::RegKey:  prdata = key_q;
      dbc_pkg::RegIv:   prdata = iv_q;
      dbc_pkg::RegMode: prdata = {61'd0, mode_q};
      dbc_pkg::RegEnc:  prdata = {63'd0, enc_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      iv_q   <= '0;
      mode_q <= dbc_pkg::ModeEcb;
      enc_q  <= 1'b1;
    end else if (wr) begin
      unique case (reg_idx)
        dbc_pkg::RegKey:  key_q  <= pwdata;
        dbc_pkg::RegIv:   iv_q   <= pwdata;
        dbc_pkg::RegMode: mode_q <= pwdata[2:0];
        dbc_pkg::RegEnc:  enc_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  dbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .rnd_o      (rnd)
  );

  dbc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .rnd_i           (rnd),
    .cipher_key_i    (key_q),
    .init_vector_i   (iv_q),
    .chain_mode_i    (mode_q),
    .encrypt_mode_i  (enc_q),
    .data_block_i    (s_axis_tdata),
    .restart_chain_i (s_axis_tuser),
    .last_block_i    (s_axis_tlast),
    .out_free_o      (out_free),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .result_block_o  (m_axis_tdata),
    .result_last_o   (m_axis_tlast)
  );
endmodule
`default_nettype wire

FILE: design/dbc_ctrl.sv
// controller: sequences load, sixteen rounds and finish for each beat
`default_nettype none
`include "des_block_cipher_modes_macros.svh"
module dbc_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   out_free_i,
  output dbc_pkg::dbc_cmd_t           cmd_o,
  output logic [dbc_pkg::RndW-1:0]    rnd_o
);
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StDone  = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [dbc_pkg::RndW-1:0] rnd_q, rnd_d;

  assign in_ready_o = (state_q == StIdle);
  assign rnd_o      = rnd_q;

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          rnd_d      = '0;
          state_d    = StRound;
        end
      end
      StRound: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 1'b1;
        if (rnd_q == dbc_pkg::RndW'(dbc_pkg::NumRounds - 1)) state_d = StDone;
      end
      StDone: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  `DBC_ASSERT_NEXT(a_load_starts, clk_i, rst_ni, cmd_o.load, state_q == StRound && rnd_q == '0)
  `DBC_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0({cmd_o.load, cmd_o.round, cmd_o.finish}))
  `DBC_ASSERT_NEXT(a_finish_idle, clk_i, rst_ni, cmd_o.finish, in_ready_o)
endmodule
`default_nettype wire

FILE: design/dbc_datapath.sv
// datapath: key schedule, feistel round register, chaining and output stage
`default_nettype none
module dbc_datapath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dbc_pkg::dbc_cmd_t      cmd_i,
  input  wire logic [dbc_pkg::RndW-1:0] rnd_i,
  input  wire logic [63:0]            cipher_key_i,
  input  wire logic [63:0]            init_vector_i,
  input  wire logic [2:0]             chain_mode_i,
  input  wire logic                   encrypt_mode_i,
  input  wire logic [63:0]            data_block_i,
  input  wire logic                   restart_chain_i,
  input  wire logic                   last_block_i,
  output logic                        out_free_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [63:0]                 result_block_o,
  output logic                        result_last_o
);
  logic [63:0] chain_q, chain_d;
  logic [63:0] x_q;
  logic        last_q;
  logic [31:0] l_q, r_q;
  logic [27:0] c_q, d_q;
  logic        dec_q;
  logic [2:0]  mode_q;
  logic        enc_q;
  logic [63:0] res_q;
  logic        lst_q;
  logic        ov_q;

  logic [63:0] chain_cur, core_in, core_out, res;
  logic [55:0] cd0;
  logic [27:0] c_rot, d_rot, c_n, d_n;
  logic [1:0]  rot;
  logic [47:0] subkey;
  logic        cbc_dec;
  logic        is_dec;

  assign chain_cur = restart_chain_i ? init_vector_i : chain_q;
  assign cbc_dec   = (chain_mode_i == dbc_pkg::ModeCbc) && !encrypt_mode_i;

  always_comb begin
    unique case (chain_mode_i)
      dbc_pkg::ModeCbc: core_in = encrypt_mode_i ? (chain_cur ^ data_block_i) : data_block_i;
      dbc_pkg::ModeCfb, dbc_pkg::ModeOfb, dbc_pkg::ModeCtr: core_in = chain_cur;
      default: core_in = data_block_i;
    endcase
    is_dec = (chain_mode_i == dbc_pkg::ModeCbc || chain_mode_i > dbc_pkg::ModeCtr ||
              chain_mode_i == dbc_pkg::ModeEcb) && !encrypt_mode_i;
  end

  assign cd0 = dbc_pkg::perm_pc1(cipher_key_i);
  assign rot = dbc_pkg::rot_amount(rnd_i);

  // encrypt rotates left before use; decrypt uses current pair then rotates right
  always_comb begin
    c_rot = (rot == 2'd1) ? {c_q[26:0], c_q[27]} : {c_q[25:0], c_q[27:26]};
    d_rot = (rot == 2'd1) ? {d_q[26:0], d_q[27]} : {d_q[25:0], d_q[27:26]};
    if (dec_q) begin
      subkey = dbc_pkg::perm_pc2({c_q, d_q});
      // right rotate by amount of round 15-rnd
      unique case (dbc_pkg::rot_amount(4'd15 - rnd_i))
        2'd1:    begin c_n = {c_q[0], c_q[27:1]};   d_n = {d_q[0], d_q[27:1]};   end
        default: begin c_n = {c_q[1:0], c_q[27:2]}; d_n = {d_q[1:0], d_q[27:2]}; end
      endcase
    end else begin
      subkey = dbc_pkg::perm_pc2({c_rot, d_rot});
      c_n = c_rot;
      d_n = d_rot;
    end
  end

  assign core_out = dbc_pkg::perm_fp({r_q, l_q});

  always_comb begin
    chain_d = chain_q;
    unique case (mode_q)
      dbc_pkg::ModeCbc: begin
        res     = enc_q ? core_out : (core_out ^ chain_q);
        chain_d = enc_q ? core_out : x_q;
      end
      dbc_pkg::ModeCfb: begin
        res     = core_out ^ x_q;
        chain_d = enc_q ? res : x_q;
      end
      dbc_pkg::ModeOfb: begin
        res     = core_out ^ x_q;
        chain_d = core_out;
      end
      dbc_pkg::ModeCtr: begin
        res     = core_out ^ x_q;
        chain_d = chain_q + 64'd1;
      end
      default: res = core_out;
    endcase
  end

  assign out_free_o     = !ov_q || out_ready_i;
  assign out_valid_o    = ov_q;
  assign result_block_o = res_q;
  assign result_last_o  = lst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cmd_i.load && restart_chain_i) chain_q <= init_vector_i;
      else if (cmd_i.finish) chain_q <= chain_d;
      if (cmd_i.finish) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      {l_q, r_q} <= dbc_pkg::perm_ip(core_in);
      // decrypt starts from the fully rotated pair, which equals the unrotated one
      c_q    <= cd0[55:28];
      d_q    <= cd0[27:0];
      dec_q  <= is_dec;
      mode_q <= chain_mode_i;
      enc_q  <= encrypt_mode_i;
      last_q <= last_block_i;
      x_q    <= cbc_dec ? data_block_i : data_block_i;
    end else if (cmd_i.round) begin
      l_q <= r_q;
      r_q <= l_q ^ dbc_pkg::feistel(r_q, subkey);
      c_q <= c_n;
      d_q <= d_n;
    end
    if (cmd_i.finish) begin
      res_q <= res;
      lst_q <= last_q;
    end
  end
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench for the des block cipher with chaining modes
`timescale 1ns / 100ps
`default_nettype none

class des_scoreboard;
  logic [63:0]  key_q;
  logic [63:0]  iv_q;
  logic [2:0]   mode_q;
  logic         enc_q;
  logic [47:0]  subkeys [16];
  logic [63:0]  chain;
  logic [64:0]  pending [$];
  int           errors;
  int           checked;

  function void clear();
    key_q = '0;
    iv_q = '0;
    mode_q = dbc_pkg::ModeEcb;
    enc_q = 1'b1;
    chain = '0;
    errors = 0;
    checked = 0;
    build_subkeys(64'd0);
  endfunction

  function void build_subkeys(logic [63:0] k);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    int          s;
    for (int i = 0; i < 56; i++) cd[55-i] = k[64-dbc_pkg::TabPc1[i]];
    c = cd[55:28];
    d = cd[27:0];
    for (int r = 0; r < 16; r++) begin
      s = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
      c = (c << s) | (c >> (28 - s));
      d = (d << s) | (d >> (28 - s));
      cd = {c, d};
      for (int i = 0; i < 48; i++) subkeys[r][47-i] = cd[56-dbc_pkg::TabPc2[i]];
    end
  endfunction

  function logic [31:0] round_fn(logic [31:0] r, logic [47:0] k);
    logic [47:0] e;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-dbc_pkg::TabE[i]];
    e ^= k;
    for (int j = 0; j < 8; j++) begin
      six = e[42-6*j +: 6];
      s[28-4*j +: 4] = dbc_pkg::TabS[j][{six[5], six[0]} * 16 + six[4:1]];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-dbc_pkg::TabP[i]];
    return p;
  endfunction

  function logic [63:0] des(logic [63:0] blk, bit inverse);
    logic [63:0] x;
    logic [63:0] y;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    for (int i = 0; i < 64; i++) x[63-i] = blk[64-dbc_pkg::TabIp[i]];
    l = x[63:32];
    r = x[31:0];
    for (int i = 0; i < 16; i++) begin
      t = r;
      r = l ^ round_fn(r, subkeys[inverse ? 15 - i : i]);
      l = t;
    end
    x = {r, l};
    for (int i = 0; i < 64; i++) y[63-i] = x[64-dbc_pkg::TabFp[i]];
    return y;
  endfunction

  function void write_reg(logic [1:0] idx, logic [63:0] v);
    case (idx)
      dbc_pkg::RegKey: begin
        key_q = v;
        build_subkeys(v);
      end
      dbc_pkg::RegIv:   iv_q = v;
      dbc_pkg::RegMode: mode_q = v[2:0];
      dbc_pkg::RegEnc:  enc_q = v[0];
      default: ;
    endcase
  endfunction

  function void note_block(logic [63:0] x, logic restart, logic last);
    logic [63:0] res;
    if (restart) chain = iv_q;
    case (mode_q)
      dbc_pkg::ModeCbc: begin
        if (enc_q) begin
          res = des(chain ^ x, 0);
          chain = res;
        end else begin
          res = des(x, 1) ^ chain;
          chain = x;
        end
      end
      dbc_pkg::ModeCfb: begin
        res = des(chain, 0) ^ x;
        chain = enc_q ? res : x;
      end
      dbc_pkg::ModeOfb: begin
        chain = des(chain, 0);
        res = chain ^ x;
      end
      dbc_pkg::ModeCtr: begin
        res = des(chain, 0) ^ x;
        chain = chain + 64'd1;
      end
      default: res = des(x, !enc_q);
    endcase
    pending.push_back({last, res});
  endfunction

  function void check_result(logic [63:0] blk, logic last);
    logic [64:0] e;
    checked++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat, actual %h last %b", $time, blk, last);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[63:0] !== blk) begin
      $display("%0t: block mismatch, expected %h actual %h", $time, e[63:0], blk);
      errors++;
    end
    if (e[64] !== last) begin
      $display("%0t: last mismatch, expected %b actual %b", $time, e[64], last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // data_block
  logic        s_axis_tuser = 1'b0; // restart_chain
  logic        s_axis_tlast = 1'b0; // last_block
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // result_block
  logic        m_axis_tlast;        // result_last

  des_scoreboard sb;
  int  cycles;
  int  hold_off;
  bit  calm;
  int  blocks_sent;

  des_block_cipher_modes dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall, long hold-off when requested
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else m_axis_tready <= calm || ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);

  task automatic apb_write(logic [1:0] idx, logic [63:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_block(logic [63:0] x, logic restart, logic last);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 23) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    s_axis_tuser <= restart;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_block(x, restart, last);
    blocks_sent++;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic set_mode(logic [2:0] m, logic e, logic [63:0] k, logic [63:0] iv);
    drain();
    apb_write(dbc_pkg::RegKey, k);
    apb_write(dbc_pkg::RegIv, iv);
    apb_write(dbc_pkg::RegMode, {61'd0, m});
    apb_write(dbc_pkg::RegEnc, {63'd0, e});
  endtask

  // short message with random content, restart at its start and at random later blocks
  task automatic send_message(int len);
    for (int i = 0; i < len; i++)
      send_block(rand64(), i == 0 || $urandom_range(19) == 0, i == len - 1);
  endtask

  initial begin
    logic [2:0] m;
    sb = new();
    sb.clear();
    cycles = 0;
    hold_off = 0;
    calm = 0;
    blocks_sent = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state, extremes, every mode in both directions
    send_block(64'd0, 1'b0, 1'b0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    set_mode(dbc_pkg::ModeEcb, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_block(64'd0, 1'b0, 1'b1);
    for (int mi = dbc_pkg::ModeCbc; mi <= dbc_pkg::ModeCtr; mi++) begin
      for (int e = 1; e >= 0; e--) begin
        set_mode(mi[2:0], e[0], 64'h1334_5779_9BBC_DFF1, 64'h0123_4567_89AB_CDEF);
        send_block(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
      end
    end
    // counter wrap and unused mode codes
    set_mode(dbc_pkg::ModeCtr, 1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'd0, 1'b1, 1'b0);
    send_block(64'd0, 1'b0, 1'b1);
    set_mode(3'd7, 1'b0, rand64(), 64'd0);
    send_block(rand64(), 1'b1, 1'b1);
    set_mode(3'd5, 1'b1, rand64(), 64'd0);
    send_block(rand64(), 1'b0, 1'b1);

    // random phases; now and then an iv rewrite between messages
    for (int p = 0; p < 24; p++) begin
      m = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      set_mode(m, 1'($urandom_range(1)), rand64(), rand64());
      calm = (p == 10);
      if (p == 6) hold_off = 300;
      for (int n = 0; n < 4; n++) send_message($urandom_range(1, 8));
      if ($urandom_range(1)) begin
        drain();
        apb_write(dbc_pkg::RegIv, rand64());
        send_message($urandom_range(1, 4));
      end
    end
    calm = 0;
    drain();
    $display("ran %0d blocks through ecb, cbc, cfb, ofb, ctr and unused codes", blocks_sent);
    $display("%0d result beats checked, both directions, with stalls", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
